// ----- rtl/skbs_pkg.sv -----
package skbs_pkg;

   localparam int KEY_W   = 64;
   localparam int CMD_W   = 2;
   localparam int POS_W   = 12;
   localparam int PROBE_W = 4;
   localparam int RSP_W   = 24;

   localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd15;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/skbs_key_ram.sv -----
module skbs_key_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [skbs_pkg::KEY_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [skbs_pkg::KEY_W-1:0]  rd_data
);
   import skbs_pkg::*;

   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sorted_key_binary_search_core.sv -----
// Sorted key table with binary search. Keys are appended in ascending order with
// command 1 (req_tuser), cleared with command 0, and looked up with command 2; command 3
// is ignored. Keys compare as unsigned big-endian values over their first KEY_BYTES
// bytes. One command is worked on at a time. A search repeats probes until the range is
// empty or a key matches. Each probe is one read of the key memory (registered read
// data) followed by one 64-bit compare. Each append and search gives one result
// transfer. The result register lets the next command be taken while a result waits, but
// a finished command is held until the result before it has left.
module sorted_key_binary_search_core #(
   parameter int TABLE_DEPTH = 4096,
   parameter int KEY_BYTES   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [skbs_pkg::KEY_W-1:0]    req_tdata,  // key
   input  logic [skbs_pkg::CMD_W-1:0]    req_tuser,  // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // found, position[12], probe_count[4], overflow, zero fill
   output logic [skbs_pkg::RSP_W-1:0]    rsp_tdata
);
   import skbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = (AW > POS_W) ? AW : POS_W;
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (8 - KEY_BYTES));
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      low_ff;
   logic [CW-1:0]      high_ff;
   logic [AW-1:0]      mid_ff;
   logic [PROBE_W-1:0] probes_ff;
   logic [KEY_W-1:0]   target_ff;
   logic               found_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               ovf_ff;
   logic               rsp_tvalid_ff;
   logic [RSP_W-1:0]   rsp_tdata_ff;

   logic               req_xfer;
   cmd_type            cmd;
   logic [CW:0]        mid_sum;
   logic [AW-1:0]      mid;
   logic               range_open;
   logic               slot_free;
   logic [KEY_W-1:0]   probe_key;
   logic               key_eq;
   logic               key_gt;
   logic [PW-1:0]      mid_wide;
   logic               wr_en;
   logic [KEY_W-1:0]   rd_data;

   assign cmd        = cmd_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   // mid = (low + high - 1) / 2, only used while low < high
   assign range_open = (low_ff < high_ff);
   assign mid_sum    = {1'b0, low_ff} + {1'b0, high_ff} - {{CW{1'b0}}, 1'b1};
   assign mid        = mid_sum[AW:1];
   assign mid_wide   = PW'(mid_ff);

   assign probe_key = rd_data & KEY_MASK;
   assign key_eq    = (target_ff == probe_key);
   assign key_gt    = (target_ff > probe_key);

   assign wr_en = req_xfer && (cmd == CMD_APPEND) && (count_ff != DEPTH_C);

   skbs_key_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (AW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (mid),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (cmd)
                  CMD_APPEND: state_in = ST_FINISH;
                  CMD_SEARCH: state_in = ST_SEARCH;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            state_in = range_open ? ST_COMPARE : ST_FINISH;
         end
         ST_COMPARE: begin
            state_in = key_eq ? ST_FINISH : ST_SEARCH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_xfer) begin
         if (cmd == CMD_CLEAR) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   // search datapath and pending result
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= '0;
         high_ff   <= '0;
         probes_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  found_ff  <= 1'b0;
                  pos_ff    <= '0;
                  probes_ff <= '0;
                  ovf_ff    <= (cmd == CMD_APPEND) && (count_ff == DEPTH_C);
                  target_ff <= req_tdata & KEY_MASK;
                  if (cmd == CMD_SEARCH) begin
                     low_ff  <= '0;
                     high_ff <= count_ff;
                  end
               end
            end
            ST_SEARCH: begin
               if (range_open) begin
                  mid_ff <= mid;
                  if (probes_ff != PROBE_MAX) begin
                     probes_ff <= probes_ff + PROBE_W'(1);
                  end
               end
            end
            ST_COMPARE: begin
               if (key_eq) begin
                  found_ff <= 1'b1;
                  pos_ff   <= mid_wide[POS_W-1:0];
               end else if (key_gt) begin
                  low_ff <= CW'(mid_ff) + CW'(1);
               end else begin
                  high_ff <= CW'(mid_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && slot_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && slot_free) begin
         rsp_tdata_ff <= {{(RSP_W - 2 - POS_W - PROBE_W){1'b0}},
                          ovf_ff, probes_ff, pos_ff, found_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMPARE |-> (CW'(mid_ff) >= low_ff && CW'(mid_ff) < high_ff))
      else $error("probe index outside search bounds");

   a_hit_has_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[0] |-> rsp_tdata_ff[16:13] != '0)
      else $error("hit reported with no probe");

   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer && cmd == CMD_SEARCH |=> state_ff == ST_SEARCH && probes_ff == '0)
      else $error("search did not start cleanly");

endmodule
